[sv/sxcrtc_pkg.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// sxcrtc_pkg - shared types and constants
// Word layouts, register indexes and mode codes of the extended CRTC
// register file.
// ---------------------------------------------------------------------------
package sxcrtc_pkg;

  // input word: one indexed byte access
  typedef struct packed {
    logic       func;
    logic [7:0] reg_index;
    logic [7:0] wdata;
  } in_word_t;

  // result word: read byte plus current display state
  typedef struct packed {
    logic [7:0] read_data;
    logic [6:0] bank;
    logic [4:0] start_addr_high;
    logic [1:0] offset_high;
    logic [2:0] pixel_mode;
    logic [2:0] clock_divisor;
    logic       mode_unsupported;
  } out_word_t;

  // read source handed from the register block to the output stage
  typedef struct packed {
    logic       use_store;
    logic [7:0] rdata;
  } rd_sel_t;

  // access kinds
  localparam logic FUNC_READ  = 1'b0;
  localparam logic FUNC_WRITE = 1'b1;

  // configuration register indexes
  localparam int          CFG_IDX_W        = 3;
  localparam int          CFG_DATA_W       = 32;
  localparam logic [2:0]  CFG_CHIP_ID_HIGH = 3'd0;
  localparam logic [2:0]  CFG_CHIP_ID_LOW  = 3'd1;
  localparam logic [2:0]  CFG_CHIP_REV     = 3'd2;
  localparam logic [2:0]  CFG_CHIP_ID_REV  = 3'd3;
  localparam logic [2:0]  CFG_STRAP_DEF    = 3'd4;
  localparam logic [2:0]  CFG_CLOCK_SEL    = 3'd5;

  // configuration reset values
  localparam logic [7:0]  CHIP_ID_HIGH_RST = 8'h56;
  localparam logic [7:0]  CHIP_ID_LOW_RST  = 8'h31;
  localparam logic [7:0]  CHIP_REV_RST     = 8'h00;
  localparam logic [7:0]  CHIP_ID_REV_RST  = 8'he1;
  localparam logic [31:0] STRAP_RESET      = 32'h000f0912;

  // cursor colour stacks
  localparam int CURSOR_STACK_DEPTH_DEF = 4;

  // register store geometry
  localparam int STORE_DEPTH = 256;
  localparam int STORE_AW    = 8;

  // keys and masks
  localparam logic [7:0] UNLOCK_KEY = 8'ha5;
  localparam logic [7:0] BASE_LAST  = 8'h18;

  // register indexes
  localparam logic [7:0] IDX_CHIP_ID_HIGH = 8'h2d;
  localparam logic [7:0] IDX_CHIP_ID_LOW  = 8'h2e;
  localparam logic [7:0] IDX_CHIP_REV     = 8'h2f;
  localparam logic [7:0] IDX_CHIP_ID_REV  = 8'h30;
  localparam logic [7:0] IDX_MEMCFG       = 8'h31;
  localparam logic [7:0] IDX_CRTLOCK      = 8'h35;
  localparam logic [7:0] IDX_STRAP0       = 8'h36;
  localparam logic [7:0] IDX_STRAP1       = 8'h37;
  localparam logic [7:0] IDX_LOCK1        = 8'h38;
  localparam logic [7:0] IDX_LOCK2        = 8'h39;
  localparam logic [7:0] IDX_MISC_3A      = 8'h3a;
  localparam logic [7:0] IDX_MISC_42      = 8'h42;
  localparam logic [7:0] IDX_MISC_43      = 8'h43;
  localparam logic [7:0] IDX_CURMODE      = 8'h45;
  localparam logic [7:0] IDX_CUR_XH       = 8'h46;
  localparam logic [7:0] IDX_CUR_XL       = 8'h47;
  localparam logic [7:0] IDX_CUR_YH       = 8'h48;
  localparam logic [7:0] IDX_CUR_YL       = 8'h49;
  localparam logic [7:0] IDX_FORE_STACK   = 8'h4a;
  localparam logic [7:0] IDX_BACK_STACK   = 8'h4b;
  localparam logic [7:0] IDX_CUR_BASE_H   = 8'h4c;
  localparam logic [7:0] IDX_CUR_BASE_L   = 8'h4d;
  localparam logic [7:0] IDX_PAT_X        = 8'h4e;
  localparam logic [7:0] IDX_PAT_Y        = 8'h4f;
  localparam logic [7:0] IDX_SYS_EXT      = 8'h51;
  localparam logic [7:0] IDX_DAC          = 8'h55;
  localparam logic [7:0] IDX_CLOCK_RB     = 8'h5c;
  localparam logic [7:0] IDX_EXT_5D       = 8'h5d;
  localparam logic [7:0] IDX_EXT_5E       = 8'h5e;
  localparam logic [7:0] IDX_MODE         = 8'h67;
  localparam logic [7:0] IDX_STRAP2       = 8'h68;
  localparam logic [7:0] IDX_START_HIGH   = 8'h69;
  localparam logic [7:0] IDX_BANK         = 8'h6a;
  localparam logic [7:0] IDX_STRAP3       = 8'h6f;

  // mode codes in bits 4..7 of the mode register
  localparam logic [3:0] MODE_CODE_BASE  = 4'h0;
  localparam logic [3:0] MODE_CODE_8BPP  = 4'h1;
  localparam logic [3:0] MODE_CODE_15BPP = 4'h3;
  localparam logic [3:0] MODE_CODE_16BPP = 4'h5;
  localparam logic [3:0] MODE_CODE_32BPP = 4'hd;

  // pixel modes
  localparam logic [2:0] PIX_PLANAR = 3'd0;
  localparam logic [2:0] PIX_8BPP   = 3'd1;
  localparam logic [2:0] PIX_15BPP  = 3'd2;
  localparam logic [2:0] PIX_16BPP  = 3'd3;
  localparam logic [2:0] PIX_32BPP  = 3'd4;

  // clock select code that routes register 0x42 to the readback
  localparam logic [1:0] CLK_SEL_EXT = 2'd3;

endpackage

[sv/sxcrtc_store.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// sxcrtc_store - generic byte store
// 256 x 8 synchronous memory with a registered read. A valid bit per
// entry, cleared by reset, makes unwritten entries read as zero.
// ---------------------------------------------------------------------------
module sxcrtc_store (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          re,
  input  logic                          we,
  input  logic [sxcrtc_pkg::STORE_AW-1:0] addr,
  input  logic [7:0]                    wdata,
  output logic [7:0]                    rdata
);

  logic [7:0]                         mem [sxcrtc_pkg::STORE_DEPTH];
  logic [sxcrtc_pkg::STORE_DEPTH-1:0] valid_r;
  logic [7:0]                         mem_q_r;
  logic                               hit_r;

  // memory array, write and registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    if (re) begin
      mem_q_r <= mem[addr];
    end
  end

  // per-entry valid bits and the valid flag of the read entry
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
      hit_r   <= 1'b0;
    end else begin
      if (we) begin
        valid_r[addr] <= 1'b1;
      end
      if (re) begin
        hit_r <= valid_r[addr];
      end
    end
  end

  // an entry never written reads as its reset value
  assign rdata = hit_r ? mem_q_r : 8'h00;

endmodule

[sv/sxcrtc_regs.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// sxcrtc_regs - named extended registers
// Write side effects, lock checks, cursor colour stacks, mode recompute and
// the read decode of the named indexes.
// ---------------------------------------------------------------------------
module sxcrtc_regs #(
  parameter int CURSOR_STACK_DEPTH = sxcrtc_pkg::CURSOR_STACK_DEPTH_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             acc,
  input  sxcrtc_pkg::in_word_t             item,
  input  logic                             cfg_we,
  input  logic [sxcrtc_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [sxcrtc_pkg::CFG_DATA_W-1:0] cfg_wdata,
  output sxcrtc_pkg::rd_sel_t              rd_sel,
  output logic [6:0]                       bank,
  output logic [4:0]                       start_addr_high,
  output logic [1:0]                       offset_high,
  output logic [2:0]                       pixel_mode,
  output logic [2:0]                       clock_divisor,
  output logic                             mode_unsupported
);

  localparam int PTR_W = $clog2(CURSOR_STACK_DEPTH);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(CURSOR_STACK_DEPTH - 1);

  // configuration registers
  logic [7:0] chip_id_high_r, chip_id_low_r, chip_rev_r, chip_id_rev_r;
  logic [1:0] clock_sel_r;

  // named state
  logic [31:0] strap_r, strap_nxt;
  logic [7:0]  lock1_r, lock1_nxt, lock2_r, lock2_nxt;
  logic [6:0]  bank_r, bank_nxt;
  logic [4:0]  start_r, start_nxt;
  logic [1:0]  offset_r, offset_nxt;
  logic [15:0] cur_x_r, cur_x_nxt, cur_y_r, cur_y_nxt, cur_base_r, cur_base_nxt;
  logic [7:0]  memcfg_r, memcfg_nxt, crtlock_r, crtlock_nxt;
  logic [7:0]  m3a_r, m3a_nxt, m42_r, m42_nxt, m43_r, m43_nxt;
  logic [7:0]  curmode_r, curmode_nxt, patx_r, patx_nxt, paty_r, paty_nxt;
  logic [7:0]  dac_r, dac_nxt, m67_r, m67_nxt;
  logic [2:0]  pix_r, pix_nxt, div_r, div_nxt;
  logic        flag_r, flag_nxt;

  // cursor colour stacks
  logic [7:0]       fore_r [CURSOR_STACK_DEPTH];
  logic [7:0]       back_r [CURSOR_STACK_DEPTH];
  logic [PTR_W-1:0] fore_ptr_r, fore_ptr_nxt, back_ptr_r, back_ptr_nxt;
  logic             fore_push, back_push;

  logic       is_wr, recompute, bank_unlocked;
  logic [7:0] idx, d;
  logic [3:0] mode_code;
  logic [2:0] base_div;

  assign is_wr = acc && (item.func == sxcrtc_pkg::FUNC_WRITE);
  assign idx   = item.reg_index;
  assign d     = item.wdata;

  // bank writes through register 0x35 open only for the key pattern in lock register 1
  assign bank_unlocked = (lock1_r[3:2] == 2'b10) && (lock1_r[7:6] != 2'b00);

  // configuration writes; strap default is fixed at reset and is not stored
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      chip_id_high_r <= sxcrtc_pkg::CHIP_ID_HIGH_RST;
      chip_id_low_r  <= sxcrtc_pkg::CHIP_ID_LOW_RST;
      chip_rev_r     <= sxcrtc_pkg::CHIP_REV_RST;
      chip_id_rev_r  <= sxcrtc_pkg::CHIP_ID_REV_RST;
      clock_sel_r    <= 2'd0;
    end else if (cfg_we) begin
      case (cfg_index)
        sxcrtc_pkg::CFG_CHIP_ID_HIGH: chip_id_high_r <= cfg_wdata[7:0];
        sxcrtc_pkg::CFG_CHIP_ID_LOW:  chip_id_low_r  <= cfg_wdata[7:0];
        sxcrtc_pkg::CFG_CHIP_REV:     chip_rev_r     <= cfg_wdata[7:0];
        sxcrtc_pkg::CFG_CHIP_ID_REV:  chip_id_rev_r  <= cfg_wdata[7:0];
        sxcrtc_pkg::CFG_CLOCK_SEL:    clock_sel_r    <= cfg_wdata[1:0];
        default: ;
      endcase
    end
  end

  // write side effects and stack pointer updates
  always_comb begin
    strap_nxt    = strap_r;
    lock1_nxt    = lock1_r;
    lock2_nxt    = lock2_r;
    bank_nxt     = bank_r;
    start_nxt    = start_r;
    offset_nxt   = offset_r;
    cur_x_nxt    = cur_x_r;
    cur_y_nxt    = cur_y_r;
    cur_base_nxt = cur_base_r;
    memcfg_nxt   = memcfg_r;
    crtlock_nxt  = crtlock_r;
    m3a_nxt      = m3a_r;
    m42_nxt      = m42_r;
    m43_nxt      = m43_r;
    curmode_nxt  = curmode_r;
    patx_nxt     = patx_r;
    paty_nxt     = paty_r;
    dac_nxt      = dac_r;
    m67_nxt      = m67_r;
    fore_ptr_nxt = fore_ptr_r;
    back_ptr_nxt = back_ptr_r;
    fore_push    = 1'b0;
    back_push    = 1'b0;
    recompute    = 1'b0;
    if (is_wr) begin
      if (idx <= sxcrtc_pkg::BASE_LAST) begin
        recompute = 1'b1;
      end
      case (idx) inside
        sxcrtc_pkg::IDX_MEMCFG: begin
          memcfg_nxt = d;
          start_nxt  = {start_r[4:2], d[5:4]};
          recompute  = 1'b1;
        end
        sxcrtc_pkg::IDX_CRTLOCK: begin
          if (bank_unlocked) begin
            crtlock_nxt = d;
            bank_nxt    = {3'b000, d[3:0]};
          end
        end
        sxcrtc_pkg::IDX_STRAP0: begin
          if (lock2_r == sxcrtc_pkg::UNLOCK_KEY) strap_nxt[7:0] = d;
        end
        sxcrtc_pkg::IDX_STRAP1: begin
          if (lock2_r == sxcrtc_pkg::UNLOCK_KEY) strap_nxt[15:8] = d;
        end
        sxcrtc_pkg::IDX_STRAP2: begin
          if (lock2_r == sxcrtc_pkg::UNLOCK_KEY) strap_nxt[23:16] = d;
        end
        sxcrtc_pkg::IDX_STRAP3: begin
          if (lock2_r == sxcrtc_pkg::UNLOCK_KEY) strap_nxt[31:24] = d;
        end
        sxcrtc_pkg::IDX_LOCK1:    lock1_nxt = d;
        sxcrtc_pkg::IDX_LOCK2:    lock2_nxt = d;
        sxcrtc_pkg::IDX_MISC_3A:  m3a_nxt = d;
        sxcrtc_pkg::IDX_MISC_42:  m42_nxt = d;
        sxcrtc_pkg::IDX_MISC_43: begin
          m43_nxt    = d;
          offset_nxt = {1'b0, d[2]};
          recompute  = 1'b1;
        end
        sxcrtc_pkg::IDX_CURMODE:    curmode_nxt = d;
        sxcrtc_pkg::IDX_CUR_XH:     cur_x_nxt[15:8] = d;
        sxcrtc_pkg::IDX_CUR_XL:     cur_x_nxt[7:0] = d;
        sxcrtc_pkg::IDX_CUR_YH:     cur_y_nxt[15:8] = d;
        sxcrtc_pkg::IDX_CUR_YL:     cur_y_nxt[7:0] = d;
        sxcrtc_pkg::IDX_FORE_STACK: begin
          fore_push    = 1'b1;
          fore_ptr_nxt = (fore_ptr_r == PTR_LAST) ? '0 : fore_ptr_r + 1'b1;
        end
        sxcrtc_pkg::IDX_BACK_STACK: begin
          back_push    = 1'b1;
          back_ptr_nxt = (back_ptr_r == PTR_LAST) ? '0 : back_ptr_r + 1'b1;
        end
        sxcrtc_pkg::IDX_CUR_BASE_H: cur_base_nxt[15:8] = d;
        sxcrtc_pkg::IDX_CUR_BASE_L: cur_base_nxt[7:0] = d;
        sxcrtc_pkg::IDX_PAT_X:      patx_nxt = d;
        sxcrtc_pkg::IDX_PAT_Y:      paty_nxt = d;
        sxcrtc_pkg::IDX_SYS_EXT: begin
          start_nxt = {start_r[4], d[1:0], start_r[1:0]};
          bank_nxt  = {1'b0, d[3:2], bank_r[3:0]};
          if (d[5:4] != 2'b00) begin
            offset_nxt = d[5:4];
          end else begin
            offset_nxt = {1'b0, m43_r[2]};
          end
          recompute = 1'b1;
        end
        sxcrtc_pkg::IDX_DAC: dac_nxt = d;
        sxcrtc_pkg::IDX_EXT_5D, sxcrtc_pkg::IDX_EXT_5E: recompute = 1'b1;
        sxcrtc_pkg::IDX_MODE: begin
          m67_nxt   = d;
          recompute = 1'b1;
        end
        sxcrtc_pkg::IDX_START_HIGH: begin
          start_nxt = d[4:0];
          recompute = 1'b1;
        end
        sxcrtc_pkg::IDX_BANK: bank_nxt = {1'b0, d[5:0]};
        default: ;
      endcase
    end else if (acc) begin
      // reading a stack returns to its bottom
      if (idx == sxcrtc_pkg::IDX_FORE_STACK) fore_ptr_nxt = '0;
      if (idx == sxcrtc_pkg::IDX_BACK_STACK) back_ptr_nxt = '0;
    end
  end

  // pixel mode and clock divisor from the updated mode registers
  assign mode_code = m67_nxt[7:4];

  always_comb begin
    pix_nxt  = sxcrtc_pkg::PIX_PLANAR;
    base_div = 3'd1;
    flag_nxt = 1'b0;
    case (mode_code)
      sxcrtc_pkg::MODE_CODE_BASE:
        pix_nxt = m3a_nxt[4] ? sxcrtc_pkg::PIX_8BPP : sxcrtc_pkg::PIX_PLANAR;
      sxcrtc_pkg::MODE_CODE_8BPP:  pix_nxt = sxcrtc_pkg::PIX_8BPP;
      sxcrtc_pkg::MODE_CODE_15BPP: begin
        pix_nxt  = sxcrtc_pkg::PIX_15BPP;
        base_div = 3'd2;
      end
      sxcrtc_pkg::MODE_CODE_16BPP: begin
        pix_nxt  = sxcrtc_pkg::PIX_16BPP;
        base_div = 3'd2;
      end
      sxcrtc_pkg::MODE_CODE_32BPP: pix_nxt = sxcrtc_pkg::PIX_32BPP;
      default:                     flag_nxt = 1'b1;
    endcase
    div_nxt = m43_nxt[7] ? {base_div[1:0], 1'b0} : base_div;
  end

  // state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      strap_r    <= sxcrtc_pkg::STRAP_RESET;
      lock1_r    <= '0;
      lock2_r    <= '0;
      bank_r     <= '0;
      start_r    <= '0;
      offset_r   <= '0;
      cur_x_r    <= '0;
      cur_y_r    <= '0;
      cur_base_r <= '0;
      memcfg_r   <= '0;
      crtlock_r  <= '0;
      m3a_r      <= '0;
      m42_r      <= '0;
      m43_r      <= '0;
      curmode_r  <= '0;
      patx_r     <= '0;
      paty_r     <= '0;
      dac_r      <= '0;
      m67_r      <= '0;
      fore_ptr_r <= '0;
      back_ptr_r <= '0;
      pix_r      <= sxcrtc_pkg::PIX_PLANAR;
      div_r      <= 3'd1;
      flag_r     <= 1'b0;
    end else begin
      strap_r    <= strap_nxt;
      lock1_r    <= lock1_nxt;
      lock2_r    <= lock2_nxt;
      bank_r     <= bank_nxt;
      start_r    <= start_nxt;
      offset_r   <= offset_nxt;
      cur_x_r    <= cur_x_nxt;
      cur_y_r    <= cur_y_nxt;
      cur_base_r <= cur_base_nxt;
      memcfg_r   <= memcfg_nxt;
      crtlock_r  <= crtlock_nxt;
      m3a_r      <= m3a_nxt;
      m42_r      <= m42_nxt;
      m43_r      <= m43_nxt;
      curmode_r  <= curmode_nxt;
      patx_r     <= patx_nxt;
      paty_r     <= paty_nxt;
      dac_r      <= dac_nxt;
      m67_r      <= m67_nxt;
      fore_ptr_r <= fore_ptr_nxt;
      back_ptr_r <= back_ptr_nxt;
      if (recompute) begin
        pix_r  <= pix_nxt;
        div_r  <= div_nxt;
        flag_r <= flag_nxt;
      end
    end
  end

  // stack entries
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < CURSOR_STACK_DEPTH; i++) begin
        fore_r[i] <= 8'hff;
        back_r[i] <= 8'h00;
      end
    end else begin
      if (fore_push) fore_r[fore_ptr_r] <= d;
      if (back_push) back_r[back_ptr_r] <= d;
    end
  end

  // read decode of the named indexes, others come from the byte store
  always_comb begin
    rd_sel.use_store = 1'b0;
    rd_sel.rdata     = 8'h00;
    if (item.func == sxcrtc_pkg::FUNC_READ) begin
      if (idx <= sxcrtc_pkg::BASE_LAST) begin
        rd_sel.use_store = 1'b1;
      end else begin
        unique case (idx)
          sxcrtc_pkg::IDX_CHIP_ID_HIGH: rd_sel.rdata = chip_id_high_r;
          sxcrtc_pkg::IDX_CHIP_ID_LOW:  rd_sel.rdata = chip_id_low_r;
          sxcrtc_pkg::IDX_CHIP_REV:     rd_sel.rdata = chip_rev_r;
          sxcrtc_pkg::IDX_CHIP_ID_REV:  rd_sel.rdata = chip_id_rev_r;
          sxcrtc_pkg::IDX_MEMCFG:       rd_sel.rdata = memcfg_r;
          sxcrtc_pkg::IDX_CRTLOCK:      rd_sel.rdata = crtlock_r;
          sxcrtc_pkg::IDX_STRAP0:       rd_sel.rdata = strap_r[7:0];
          sxcrtc_pkg::IDX_STRAP1:       rd_sel.rdata = strap_r[15:8];
          sxcrtc_pkg::IDX_LOCK1:        rd_sel.rdata = lock1_r;
          sxcrtc_pkg::IDX_LOCK2:        rd_sel.rdata = lock2_r;
          sxcrtc_pkg::IDX_MISC_42:      rd_sel.rdata = {4'h0, m42_r[3:0]};
          sxcrtc_pkg::IDX_MISC_43:      rd_sel.rdata = m43_r;
          sxcrtc_pkg::IDX_CURMODE:      rd_sel.rdata = curmode_r;
          sxcrtc_pkg::IDX_CUR_XH:       rd_sel.rdata = cur_x_r[15:8];
          sxcrtc_pkg::IDX_CUR_XL:       rd_sel.rdata = cur_x_r[7:0];
          sxcrtc_pkg::IDX_CUR_YH:       rd_sel.rdata = cur_y_r[15:8];
          sxcrtc_pkg::IDX_CUR_YL:       rd_sel.rdata = cur_y_r[7:0];
          sxcrtc_pkg::IDX_FORE_STACK:   rd_sel.rdata = fore_r[fore_ptr_r];
          sxcrtc_pkg::IDX_BACK_STACK:   rd_sel.rdata = back_r[back_ptr_r];
          sxcrtc_pkg::IDX_CUR_BASE_H:   rd_sel.rdata = cur_base_r[15:8];
          sxcrtc_pkg::IDX_CUR_BASE_L:   rd_sel.rdata = cur_base_r[7:0];
          sxcrtc_pkg::IDX_PAT_X:        rd_sel.rdata = patx_r;
          sxcrtc_pkg::IDX_PAT_Y:        rd_sel.rdata = paty_r;
          sxcrtc_pkg::IDX_SYS_EXT:      rd_sel.rdata = {4'h0, bank_r[5:4], start_r[3:2]};
          sxcrtc_pkg::IDX_DAC:          rd_sel.rdata = dac_r;
          sxcrtc_pkg::IDX_CLOCK_RB:
            rd_sel.rdata = (clock_sel_r == sxcrtc_pkg::CLK_SEL_EXT) ?
                           {4'h0, m42_r[3:0]} : {6'h00, clock_sel_r};
          sxcrtc_pkg::IDX_MODE:         rd_sel.rdata = m67_r;
          sxcrtc_pkg::IDX_STRAP2:       rd_sel.rdata = strap_r[23:16];
          sxcrtc_pkg::IDX_START_HIGH:   rd_sel.rdata = {3'b000, start_r};
          sxcrtc_pkg::IDX_BANK:         rd_sel.rdata = {1'b0, bank_r};
          sxcrtc_pkg::IDX_STRAP3:       rd_sel.rdata = strap_r[31:24];
          default:                      rd_sel.use_store = 1'b1;
        endcase
      end
    end
  end

  assign bank             = bank_r;
  assign start_addr_high  = start_r;
  assign offset_high      = offset_r;
  assign pixel_mode       = pix_r;
  assign clock_divisor    = div_r;
  assign mode_unsupported = flag_r;

  // unknown mode code always falls back to planar
  a_flag_planar: assert property (@(posedge clk) disable iff (!rst_n)
    flag_r |-> (pix_r == sxcrtc_pkg::PIX_PLANAR))
    else $error("unsupported mode flag with non-planar pixel mode");

  // divisor is one, two or four
  a_div_legal: assert property (@(posedge clk) disable iff (!rst_n)
    (div_r == 3'd1) || (div_r == 3'd2) || (div_r == 3'd4))
    else $error("clock divisor out of range");

  // a fore stack read leaves its pointer at the bottom
  a_fore_rewind: assert property (@(posedge clk) disable iff (!rst_n)
    (acc && (item.func == sxcrtc_pkg::FUNC_READ) &&
     (idx == sxcrtc_pkg::IDX_FORE_STACK)) |=> (fore_ptr_r == '0))
    else $error("fore stack pointer not cleared by read");

endmodule

[sv/svga_extended_crtc_registers_core.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// svga_extended_crtc_registers_core - extended CRTC register file
// Indexed byte reads and writes over a generic byte store and the named
// extended registers, with the resulting display state on every result.
//
// channel   ports                          direction
// input     start, busy, in_word           in (busy out)
// result    out_strobe, out_word           out
// config    cfg_we, cfg_index, cfg_wdata   in
//
// One word is taken per cycle; its result shows for one cycle, the cycle
// after it is taken, as the byte store read is registered.
// busy stays low: each word writes the store on the edge that takes it, so
// the next word already reads the updated entry.
// Reset is synchronous; the store's valid bits clear at once, so there is
// no clearing pass. The receiver cannot stall the result.
// ---------------------------------------------------------------------------
module svga_extended_crtc_registers_core #(
  parameter int CURSOR_STACK_DEPTH = sxcrtc_pkg::CURSOR_STACK_DEPTH_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              start,
  output logic                              busy,
  input  sxcrtc_pkg::in_word_t              in_word,
  output logic                              out_strobe,
  output sxcrtc_pkg::out_word_t             out_word,
  input  logic                              cfg_we,
  input  logic [sxcrtc_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [sxcrtc_pkg::CFG_DATA_W-1:0] cfg_wdata
);

  logic                acc;
  sxcrtc_pkg::rd_sel_t rd_sel;
  logic                use_store_r;
  logic [7:0]          rdata_r;
  logic                strobe_r;
  logic [7:0]          store_rdata;

  assign busy = 1'b0;
  assign acc  = start && !busy;

  // generic byte store
  sxcrtc_store u_store (
    .clk   (clk),
    .rst_n (rst_n),
    .re    (acc),
    .we    (acc && (in_word.func == sxcrtc_pkg::FUNC_WRITE)),
    .addr  (in_word.reg_index),
    .wdata (in_word.wdata),
    .rdata (store_rdata)
  );

  // named registers
  sxcrtc_regs #(
    .CURSOR_STACK_DEPTH (CURSOR_STACK_DEPTH)
  ) u_regs (
    .clk              (clk),
    .rst_n            (rst_n),
    .acc              (acc),
    .item             (in_word),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_wdata        (cfg_wdata),
    .rd_sel           (rd_sel),
    .bank             (out_word.bank),
    .start_addr_high  (out_word.start_addr_high),
    .offset_high      (out_word.offset_high),
    .pixel_mode       (out_word.pixel_mode),
    .clock_divisor    (out_word.clock_divisor),
    .mode_unsupported (out_word.mode_unsupported)
  );

  // result strobe
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      strobe_r <= 1'b0;
    end else begin
      strobe_r <= acc;
    end
  end

  // read source held alongside the store read
  always_ff @(posedge clk) begin
    if (acc) begin
      use_store_r <= rd_sel.use_store;
      rdata_r     <= rd_sel.rdata;
    end
  end

  assign out_strobe         = strobe_r;
  assign out_word.read_data = use_store_r ? store_rdata : rdata_r;

  // every taken word gives exactly one result on the next cycle
  a_one_result: assert property (@(posedge clk) disable iff (!rst_n)
    acc |=> out_strobe)
    else $error("taken word gave no result");

  a_no_extra: assert property (@(posedge clk) disable iff (!rst_n)
    !acc |=> !out_strobe)
    else $error("result without a taken word");

  // a write never reports read data
  a_write_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (acc && (in_word.func == sxcrtc_pkg::FUNC_WRITE)) |=> (out_word.read_data == 8'h00))
    else $error("write result carries read data");

endmodule

[sim/crtc_result_checker.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// crtc_result_checker - result predictor and comparator
// Watches the access, result and configuration ports of the extended CRTC
// register file, keeps its own copy of the register state, works out the
// result word of every accepted access and compares each result word
// field by field with the oldest prediction.
// ---------------------------------------------------------------------------
module crtc_result_checker
  import sxcrtc_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  input  logic                  busy,
  input  in_word_t              in_word,
  input  logic                  out_strobe,
  input  out_word_t             out_word,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  output int                    mismatch_count,
  output int                    words_waiting
);

  localparam int STACK_DEPTH  = CURSOR_STACK_DEPTH_DEF;
  localparam int REPORT_LIMIT = 100;

  // configuration copy
  logic [7:0]  id_high, id_low, chip_rev, id_rev;
  logic [1:0]  clk_sel;

  // register state copy
  logic [7:0]  byte_store [STORE_DEPTH];
  logic [31:0] strap_word;
  logic [7:0]  lock_one, lock_two;
  logic [6:0]  bank_num;
  logic [4:0]  start_high;
  logic [1:0]  offset_high;
  logic [7:0]  fore_stack [STACK_DEPTH];
  logic [7:0]  back_stack [STACK_DEPTH];
  int unsigned fore_ptr, back_ptr;
  logic [15:0] cur_x, cur_y, cur_base;
  logic [7:0]  mem_cfg, crt_lock, misc_3a, misc_42, misc_43;
  logic [7:0]  cur_mode, pat_x, pat_y, dac_ctl, mode_reg;
  logic [2:0]  pix_mode, clk_div;
  logic        mode_bad;

  out_word_t   expected_words [$];
  out_word_t   want;
  int          fails = 0;

  initial begin
    mismatch_count = 0;
    words_waiting  = 0;
  end

  // power-on state, strap word from the default strapping
  function automatic void reset_state();
    for (int i = 0; i < STORE_DEPTH; i++) byte_store[i] = '0;
    for (int i = 0; i < STACK_DEPTH; i++) begin
      fore_stack[i] = 8'hff;
      back_stack[i] = 8'h00;
    end
    id_high    = CHIP_ID_HIGH_RST;
    id_low     = CHIP_ID_LOW_RST;
    chip_rev   = CHIP_REV_RST;
    id_rev     = CHIP_ID_REV_RST;
    clk_sel    = '0;
    strap_word = STRAP_RESET;
    lock_one   = '0;
    lock_two   = '0;
    bank_num   = '0;
    start_high = '0;
    offset_high = '0;
    fore_ptr   = 0;
    back_ptr   = 0;
    cur_x      = '0;
    cur_y      = '0;
    cur_base   = '0;
    mem_cfg    = '0;
    crt_lock   = '0;
    misc_3a    = '0;
    misc_42    = '0;
    misc_43    = '0;
    cur_mode   = '0;
    pat_x      = '0;
    pat_y      = '0;
    dac_ctl    = '0;
    mode_reg   = '0;
    pix_mode   = PIX_PLANAR;
    clk_div    = 3'd1;
    mode_bad   = 1'b0;
  endfunction

  // pixel mode and divisor from the mode code, doubling from bit 7 of 0x43
  function automatic void update_mode();
    logic [2:0] pix;
    logic [2:0] div;
    logic       bad;
    pix = PIX_PLANAR;
    div = 3'd1;
    bad = 1'b0;
    case (mode_reg[7:4])
      MODE_CODE_BASE:  pix = misc_3a[4] ? PIX_8BPP : PIX_PLANAR;
      MODE_CODE_8BPP:  pix = PIX_8BPP;
      MODE_CODE_15BPP: begin
        pix = PIX_15BPP;
        div = 3'd2;
      end
      MODE_CODE_16BPP: begin
        pix = PIX_16BPP;
        div = 3'd2;
      end
      MODE_CODE_32BPP: pix = PIX_32BPP;
      default:         bad = 1'b1;
    endcase
    if (misc_43[7]) div = div << 1;
    pix_mode = pix;
    clk_div  = div;
    mode_bad = bad;
  endfunction

  // read side, stack reads rewind their pointer
  function automatic logic [7:0] read_byte(logic [7:0] idx);
    logic [7:0] r;
    if (idx <= BASE_LAST) return byte_store[idx];
    case (idx)
      IDX_CHIP_ID_HIGH: r = id_high;
      IDX_CHIP_ID_LOW:  r = id_low;
      IDX_CHIP_REV:     r = chip_rev;
      IDX_CHIP_ID_REV:  r = id_rev;
      IDX_MEMCFG:       r = mem_cfg;
      IDX_CRTLOCK:      r = crt_lock;
      IDX_STRAP0:       r = strap_word[7:0];
      IDX_STRAP1:       r = strap_word[15:8];
      IDX_LOCK1:        r = lock_one;
      IDX_LOCK2:        r = lock_two;
      IDX_MISC_42:      r = {4'b0, misc_42[3:0]};
      IDX_MISC_43:      r = misc_43;
      IDX_CURMODE:      r = cur_mode;
      IDX_CUR_XH:       r = cur_x[15:8];
      IDX_CUR_XL:       r = cur_x[7:0];
      IDX_CUR_YH:       r = cur_y[15:8];
      IDX_CUR_YL:       r = cur_y[7:0];
      IDX_FORE_STACK: begin
        r = fore_stack[fore_ptr];
        fore_ptr = 0;
      end
      IDX_BACK_STACK: begin
        r = back_stack[back_ptr];
        back_ptr = 0;
      end
      IDX_CUR_BASE_H:   r = cur_base[15:8];
      IDX_CUR_BASE_L:   r = cur_base[7:0];
      IDX_PAT_X:        r = pat_x;
      IDX_PAT_Y:        r = pat_y;
      IDX_SYS_EXT:      r = {4'b0, bank_num[5:4], start_high[3:2]};
      IDX_DAC:          r = dac_ctl;
      IDX_CLOCK_RB:     r = (clk_sel == CLK_SEL_EXT) ? {4'b0, misc_42[3:0]} : {6'b0, clk_sel};
      IDX_MODE:         r = mode_reg;
      IDX_STRAP2:       r = strap_word[23:16];
      IDX_START_HIGH:   r = {3'b0, start_high};
      IDX_BANK:         r = {1'b0, bank_num};
      IDX_STRAP3:       r = strap_word[31:24];
      default:          r = byte_store[idx];
    endcase
    return r;
  endfunction

  // write side, the generic byte is always stored first
  function automatic void write_byte(logic [7:0] idx, logic [7:0] d);
    byte_store[idx] = d;
    if (idx <= BASE_LAST) begin
      update_mode();
      return;
    end
    case (idx)
      IDX_MEMCFG: begin
        mem_cfg    = d;
        start_high = {start_high[4:2], d[5:4]};
        update_mode();
      end
      IDX_CRTLOCK: begin
        // bank only opens with the key pattern in the first lock
        if (lock_one[3:2] == 2'b10 && lock_one[7:6] != 2'b00) begin
          crt_lock = d;
          bank_num = {3'b0, d[3:0]};
        end
      end
      IDX_STRAP0: if (lock_two == UNLOCK_KEY) strap_word[7:0]   = d;
      IDX_STRAP1: if (lock_two == UNLOCK_KEY) strap_word[15:8]  = d;
      IDX_STRAP2: if (lock_two == UNLOCK_KEY) strap_word[23:16] = d;
      IDX_STRAP3: if (lock_two == UNLOCK_KEY) strap_word[31:24] = d;
      IDX_LOCK1:   lock_one = d;
      IDX_LOCK2:   lock_two = d;
      IDX_MISC_3A: misc_3a  = d;
      IDX_MISC_42: misc_42  = d;
      IDX_MISC_43: begin
        misc_43     = d;
        offset_high = {1'b0, d[2]};
        update_mode();
      end
      IDX_CURMODE:    cur_mode       = d;
      IDX_CUR_XH:     cur_x[15:8]    = d;
      IDX_CUR_XL:     cur_x[7:0]     = d;
      IDX_CUR_YH:     cur_y[15:8]    = d;
      IDX_CUR_YL:     cur_y[7:0]     = d;
      IDX_CUR_BASE_H: cur_base[15:8] = d;
      IDX_CUR_BASE_L: cur_base[7:0]  = d;
      // colour stacks wrap round
      IDX_FORE_STACK: begin
        fore_stack[fore_ptr] = d;
        fore_ptr = (fore_ptr + 1) % STACK_DEPTH;
      end
      IDX_BACK_STACK: begin
        back_stack[back_ptr] = d;
        back_ptr = (back_ptr + 1) % STACK_DEPTH;
      end
      IDX_PAT_X: pat_x = d;
      IDX_PAT_Y: pat_y = d;
      IDX_SYS_EXT: begin
        start_high = {start_high[4], d[1:0], start_high[1:0]};
        bank_num   = {bank_num[6], d[3:2], bank_num[3:0]};
        if (d[5:4] != 2'b00) offset_high = d[5:4];
        else offset_high = {1'b0, misc_43[2]};
        update_mode();
      end
      IDX_DAC: dac_ctl = d;
      IDX_EXT_5D, IDX_EXT_5E: update_mode();
      IDX_MODE: begin
        mode_reg = d;
        update_mode();
      end
      IDX_START_HIGH: begin
        start_high = d[4:0];
        update_mode();
      end
      IDX_BANK: bank_num = {1'b0, d[5:0]};
      default: ;
    endcase
  endfunction

  // result word of one access
  function automatic out_word_t crtc_access(in_word_t w);
    out_word_t r;
    r = '0;
    if (w.func == FUNC_WRITE) write_byte(w.reg_index, w.wdata);
    else r.read_data = read_byte(w.reg_index);
    r.bank             = bank_num;
    r.start_addr_high  = start_high;
    r.offset_high      = offset_high;
    r.pixel_mode       = pix_mode;
    r.clock_divisor    = clk_div;
    r.mode_unsupported = mode_bad;
    return r;
  endfunction

  // strap default writes are ignored; the strap word resets to STRAP_RESET
  function automatic void apply_cfg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] v);
    case (idx)
      CFG_CHIP_ID_HIGH: id_high  = v[7:0];
      CFG_CHIP_ID_LOW:  id_low   = v[7:0];
      CFG_CHIP_REV:     chip_rev = v[7:0];
      CFG_CHIP_ID_REV:  id_rev   = v[7:0];
      CFG_CLOCK_SEL:    clk_sel  = v[1:0];
      default: ;
    endcase
  endfunction

  task automatic check_field(string field, logic [7:0] exp_v, logic [7:0] act_v);
    if (act_v !== exp_v) begin
      fails++;
      if (fails <= REPORT_LIMIT)
        $display("%0t ns: %s mismatch, expected 0x%0h, got 0x%0h",
                 $time, field, exp_v, act_v);
    end
  endtask

  // compare results, then take config writes and new access words
  always @(posedge clk) begin
    if (!rst_n) begin
      reset_state();
      expected_words.delete();
    end else begin
      if (out_strobe) begin
        if (expected_words.size() == 0) begin
          fails++;
          $display("%0t ns: result word with no access waiting, expected none, got 0x%0h",
                   $time, out_word);
        end else begin
          want = expected_words.pop_front();
          check_field("read_data",        want.read_data,        out_word.read_data);
          check_field("bank",             want.bank,             out_word.bank);
          check_field("start_addr_high",  want.start_addr_high,  out_word.start_addr_high);
          check_field("offset_high",      want.offset_high,      out_word.offset_high);
          check_field("pixel_mode",       want.pixel_mode,       out_word.pixel_mode);
          check_field("clock_divisor",    want.clock_divisor,    out_word.clock_divisor);
          check_field("mode_unsupported", want.mode_unsupported, out_word.mode_unsupported);
        end
      end
      if (cfg_we) apply_cfg(cfg_index, cfg_wdata);
      if (start && !busy) expected_words.push_back(crtc_access(in_word));
    end
    words_waiting  <= expected_words.size();
    mismatch_count <= fails;
  end

endmodule

[sim/testbench.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// testbench - extended CRTC register file test
// Drives directed and random indexed byte accesses, with random idle gaps in
// all but one phase, runs through several configuration settings and leaves
// prediction and comparison to the result checker beside the block.
// ---------------------------------------------------------------------------
module testbench;
  import sxcrtc_pkg::*;

  localparam int WATCHDOG_LIMIT = 500;
  localparam int PHASE_WORDS    = 340;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  start = 1'b0;
  logic                  busy;
  in_word_t              in_word = '0;
  logic                  out_strobe;
  out_word_t             out_word;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;

  int mismatch_count;
  int words_waiting;
  int words_sent = 0;
  int reads_sent = 0;
  int settings_used = 1;
  int idle_cycles = 0;
  bit gaps_on = 1'b1;

  always #10 clk = ~clk;

  svga_extended_crtc_registers_core DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .busy       (busy),
    .in_word    (in_word),
    .out_strobe (out_strobe),
    .out_word   (out_word),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata)
  );

  crtc_result_checker checker_i (
    .clk            (clk),
    .rst_n          (rst_n),
    .start          (start),
    .busy           (busy),
    .in_word        (in_word),
    .out_strobe     (out_strobe),
    .out_word       (out_word),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_wdata      (cfg_wdata),
    .mismatch_count (mismatch_count),
    .words_waiting  (words_waiting)
  );

  // watchdog on cycles with no transfer on any port
  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_strobe || cfg_we) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t ns: watchdog, no transfer for %0d cycles", $time, idle_cycles);
      $display("[svga_extended_crtc_registers_core] ERROR");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // one access word, with random idle cycles ahead of it while gaps are on
  task automatic send_access(logic f, logic [7:0] idx, logic [7:0] d);
    while (gaps_on && $urandom_range(99) < 37) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start   <= 1'b1;
    in_word <= '{func: f, reg_index: idx, wdata: d};
    do @(posedge clk); while (busy);
    words_sent++;
    if (f == FUNC_READ) reads_sent++;
  endtask

  // hold off until every predicted result word has come back
  task automatic drain();
    start <= 1'b0;
    @(posedge clk);
    while (words_waiting != 0) @(posedge clk);
  endtask

  task automatic write_cfg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] v);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= v;
    @(posedge clk);
  endtask

  function automatic logic [7:0] pick_named_index();
    case ($urandom_range(0, 34))
      0:  return IDX_CHIP_ID_HIGH;   1:  return IDX_CHIP_ID_LOW;
      2:  return IDX_CHIP_REV;       3:  return IDX_CHIP_ID_REV;
      4:  return IDX_MEMCFG;         5:  return IDX_CRTLOCK;
      6:  return IDX_STRAP0;         7:  return IDX_STRAP1;
      8:  return IDX_LOCK1;          9:  return IDX_LOCK2;
      10: return IDX_MISC_3A;        11: return IDX_MISC_42;
      12: return IDX_MISC_43;        13: return IDX_CURMODE;
      14: return IDX_CUR_XH;         15: return IDX_CUR_XL;
      16: return IDX_CUR_YH;         17: return IDX_CUR_YL;
      18: return IDX_FORE_STACK;     19: return IDX_BACK_STACK;
      20: return IDX_CUR_BASE_H;     21: return IDX_CUR_BASE_L;
      22: return IDX_PAT_X;          23: return IDX_PAT_Y;
      24: return IDX_SYS_EXT;        25: return IDX_DAC;
      26: return IDX_CLOCK_RB;       27: return IDX_EXT_5D;
      28: return IDX_EXT_5E;         29: return IDX_MODE;
      30: return IDX_STRAP2;         31: return IDX_START_HIGH;
      32: return IDX_BANK;           33: return IDX_STRAP3;
      default: return 8'($urandom_range(0, BASE_LAST));
    endcase
  endfunction

  function automatic logic [3:0] pick_mode_code();
    case ($urandom_range(0, 5))
      0: return MODE_CODE_BASE;
      1: return MODE_CODE_8BPP;
      2: return MODE_CODE_15BPP;
      3: return MODE_CODE_16BPP;
      4: return MODE_CODE_32BPP;
      default: return 4'($urandom_range(15));
    endcase
  endfunction

  // new settings with nothing in flight, then a stretch of random words
  task automatic run_phase(logic [7:0] id_hi, logic [7:0] id_lo, logic [7:0] rev,
                           logic [7:0] id_rv, logic [31:0] strap, logic [1:0] clk_sel,
                           bit gaps);
    int         target;
    int         pick;
    int         n;
    logic [7:0] idx;
    logic [7:0] v;
    drain();
    write_cfg(CFG_CHIP_ID_HIGH, {24'b0, id_hi});
    write_cfg(CFG_CHIP_ID_LOW,  {24'b0, id_lo});
    write_cfg(CFG_CHIP_REV,     {24'b0, rev});
    write_cfg(CFG_CHIP_ID_REV,  {24'b0, id_rv});
    write_cfg(CFG_STRAP_DEF,    strap);
    write_cfg(CFG_CLOCK_SEL,    {30'b0, clk_sel});
    cfg_we <= 1'b0;
    settings_used++;
    gaps_on = gaps;
    target  = words_sent + PHASE_WORDS;
    while (words_sent < target) begin
      pick = $urandom_range(99);
      if (pick < 25) begin
        // raw noise over the whole index space
        send_access(1'($urandom_range(1)), 8'($urandom()), 8'($urandom()));
      end else if (pick < 55) begin
        send_access(1'($urandom_range(1)), pick_named_index(), 8'($urandom()));
      end else if (pick < 67) begin
        // bank unlock: key pattern in the first lock, then the bank write
        v = 8'($urandom());
        if ($urandom_range(99) < 80) begin
          v[3:2] = 2'b10;
          if ($urandom_range(3) != 0 && v[7:6] == 2'b00) v[7] = 1'b1;
        end
        send_access(FUNC_WRITE, IDX_LOCK1, v);
        send_access(FUNC_WRITE, IDX_CRTLOCK, 8'($urandom()));
        send_access(FUNC_READ, $urandom_range(1) ? IDX_CRTLOCK : IDX_BANK, 8'($urandom()));
      end else if (pick < 77) begin
        // strap byte behind the second lock
        send_access(FUNC_WRITE, IDX_LOCK2,
                    ($urandom_range(99) < 80) ? UNLOCK_KEY : 8'($urandom()));
        case ($urandom_range(3))
          0: idx = IDX_STRAP0;
          1: idx = IDX_STRAP1;
          2: idx = IDX_STRAP2;
          default: idx = IDX_STRAP3;
        endcase
        send_access(FUNC_WRITE, idx, 8'($urandom()));
        send_access(FUNC_READ, idx, 8'($urandom()));
      end else if (pick < 89) begin
        // colour stack burst, often past its depth, then a read back
        idx = $urandom_range(1) ? IDX_FORE_STACK : IDX_BACK_STACK;
        n = $urandom_range(1, 6);
        repeat (n) send_access(FUNC_WRITE, idx, 8'($urandom()));
        send_access(FUNC_READ, idx, 8'($urandom()));
        if ($urandom_range(1)) send_access(FUNC_READ, idx, 8'($urandom()));
      end else begin
        // mode recompute inputs, then a trigger or readback
        if ($urandom_range(1)) send_access(FUNC_WRITE, IDX_MISC_3A, 8'($urandom()));
        if ($urandom_range(1)) send_access(FUNC_WRITE, IDX_MISC_43, 8'($urandom()));
        if ($urandom_range(1)) send_access(FUNC_WRITE, IDX_MISC_42, 8'($urandom()));
        send_access(FUNC_WRITE, IDX_MODE, {pick_mode_code(), 4'($urandom())});
        case ($urandom_range(3))
          0: send_access(FUNC_WRITE, 8'($urandom_range(0, BASE_LAST)), 8'($urandom()));
          1: send_access(FUNC_WRITE, $urandom_range(1) ? IDX_EXT_5D : IDX_EXT_5E,
                         8'($urandom()));
          2: send_access(FUNC_READ, IDX_CLOCK_RB, 8'($urandom()));
          default: send_access(FUNC_WRITE, IDX_SYS_EXT, 8'($urandom()));
        endcase
      end
    end
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // identity bytes, clock readback and stacks straight after reset
    send_access(FUNC_READ,  IDX_CHIP_ID_HIGH, 8'h00);
    send_access(FUNC_READ,  IDX_CHIP_ID_LOW,  8'h00);
    send_access(FUNC_READ,  IDX_CHIP_REV,     8'h00);
    send_access(FUNC_READ,  IDX_CHIP_ID_REV,  8'h00);
    send_access(FUNC_READ,  IDX_CLOCK_RB,     8'hff);
    send_access(FUNC_READ,  IDX_FORE_STACK,   8'h00);
    send_access(FUNC_READ,  IDX_BACK_STACK,   8'h00);
    // locked bank write, then unlocked
    send_access(FUNC_WRITE, IDX_CRTLOCK,      8'hff);
    send_access(FUNC_WRITE, IDX_LOCK1,        8'h48);
    send_access(FUNC_WRITE, IDX_CRTLOCK,      8'hff);
    // strap bytes behind the key
    send_access(FUNC_WRITE, IDX_LOCK2,        UNLOCK_KEY);
    send_access(FUNC_WRITE, IDX_STRAP0,       8'h00);
    send_access(FUNC_WRITE, IDX_STRAP3,       8'hff);
    send_access(FUNC_READ,  IDX_STRAP3,       8'h00);
    // stack wraps after four writes
    send_access(FUNC_WRITE, IDX_FORE_STACK,   8'h11);
    send_access(FUNC_WRITE, IDX_FORE_STACK,   8'h22);
    send_access(FUNC_WRITE, IDX_FORE_STACK,   8'h33);
    send_access(FUNC_WRITE, IDX_FORE_STACK,   8'h44);
    send_access(FUNC_WRITE, IDX_FORE_STACK,   8'h55);
    send_access(FUNC_READ,  IDX_FORE_STACK,   8'h00);
    // divisor doubling, 32bpp, unknown code, high bits
    send_access(FUNC_WRITE, IDX_MISC_43,      8'h84);
    send_access(FUNC_WRITE, IDX_MODE,         {MODE_CODE_32BPP, 4'h0});
    send_access(FUNC_WRITE, IDX_MODE,         8'h20);
    send_access(FUNC_WRITE, IDX_SYS_EXT,      8'h3f);
    send_access(FUNC_WRITE, IDX_BANK,         8'hff);
    send_access(FUNC_READ,  IDX_SYS_EXT,      8'h00);

    // settings: low extremes, high extremes, then random ones
    run_phase(8'h00, 8'h00, 8'h00, 8'h00, 32'h0000_0000, 2'd0, 1'b1);
    run_phase(8'hff, 8'hff, 8'hff, 8'hff, 32'hffff_ffff, CLK_SEL_EXT, 1'b1);
    run_phase(8'($urandom()), 8'($urandom()), 8'($urandom()), 8'($urandom()),
              $urandom(), 2'd1, 1'b0);
    run_phase(8'($urandom()), 8'($urandom()), 8'($urandom()), 8'($urandom()),
              $urandom(), 2'd2, 1'b1);
    run_phase(8'($urandom()), 8'($urandom()), 8'($urandom()), 8'($urandom()),
              $urandom(), CLK_SEL_EXT, 1'b1);

    drain();
    repeat (4) @(posedge clk);
    $display("run: %0d accesses (%0d reads, %0d writes) under %0d register settings",
             words_sent, reads_sent, words_sent - reads_sent, settings_used);
    $display("run: bank and strap locks, colour stack wrap, mode codes and clock readback");
    if (mismatch_count == 0) begin
      $display("[svga_extended_crtc_registers_core] OK");
    end else begin
      $display("[svga_extended_crtc_registers_core] ERROR");
    end
    $finish;
  end

endmodule
